@@ hw/rtl/qas_pkg.sv @@
// Package: types, codes and constants shared by the argument splitter modules.
`timescale 1ns / 1ps
`default_nettype none

package qas_pkg;

  localparam int unsigned QAS_RES_DEPTH = 4;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_PLAIN  = 3'd1,
    MODE_SQ     = 3'd2,
    MODE_DQ     = 3'd3,
    MODE_SQ_ESC = 3'd4,
    MODE_DQ_ESC = 3'd5
  } scan_mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_line;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  token_byte;
    logic [15:0] token_index;
    logic        last_of_run;
  } result_t;

  // Results produced by one item: up to two, r0 first.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

@@ hw/rtl/qas_stream_if.sv @@
// Valid/ready stream interface carrying one payload per beat.
`timescale 1ns / 1ps
`default_nettype none

interface qas_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/quoted_argument_splitter_unit.sv @@
// Top level of the quoted argument splitter: input register, decode, result queue.
//
// Usage:
//   item_i carries one command line character per beat (byte_in) or the end
//   of line marker (end_of_line). result_o carries token bytes, token ends,
//   and one done or error result per line, each with its token index;
//   last_of_run marks the final result of an input beat.
//   An input beat is taken every cycle while the result side keeps up; a
//   beat waits in the input register until the result queue has room for
//   two results. End of line inside a bare token yields two results, which
//   drain at one per cycle while the receiver is ready.
//   A result passes the input register and then the result queue before it
//   is offered on result_o.
//   Throughput: one input beat per cycle while each beat yields one result
//   and the receiver takes one per cycle; two-result beats and stalls slow it.
//   Reset: scan mode goes idle, token count to zero, queue empties.
//   When the receiver stalls, results pile up in the queue; once fewer than
//   two slots remain free, a beat in the input register holds item_i.ready low.
`timescale 1ns / 1ps
`default_nettype none

module quoted_argument_splitter_unit #(
  parameter int unsigned ResDepth = qas_pkg::QAS_RES_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  qas_stream_if.sink   item_i,
  qas_stream_if.source result_o
);
  import qas_pkg::*;

  logic  s1_valid_q;
  item_t s1_item_q;
  logic  room;
  logic  s1_fire;
  push_t push;
  push_t push_gated;

  assign s1_fire     = s1_valid_q && room;
  assign item_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      s1_item_q <= item_i.data;
    end
  end

  qas_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .item_i (s1_item_q),
    .push_o (push)
  );

  always_comb begin
    push_gated = push;
    if (!s1_fire) begin
      push_gated.count = 2'd0;
    end
  end

  qas_result_fifo #(
    .Depth (ResDepth)
  ) u_result_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_gated),
    .room_o (room),
    .res_o  (result_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/qas_decode.sv @@
// Scan mode machine: decides the results of one character beat.
`timescale 1ns / 1ps
`default_nettype none

module qas_decode (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire qas_pkg::item_t item_i,
  output qas_pkg::push_t      push_o
);
  import qas_pkg::*;

  scan_mode_e  mode_q, mode_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] cnt_bump;
  logic [7:0]  b;
  logic        eol;
  logic        is_sep;

  assign b        = item_i.byte_in;
  assign eol      = item_i.end_of_line;
  assign is_sep   = (b == CHAR_SPACE) || (b == CHAR_TAB);
  assign cnt_bump = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + 16'd1;

  // Next state
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    if (eol) begin
      mode_d = MODE_IDLE;
      cnt_d  = '0;
    end else begin
      unique case (mode_q)
        MODE_PLAIN: begin
          if (is_sep) begin
            mode_d = MODE_IDLE;
            cnt_d  = cnt_bump;
          end
        end
        MODE_SQ, MODE_DQ: begin
          if ((mode_q == MODE_SQ && b == CHAR_SQUOTE) ||
              (mode_q == MODE_DQ && b == CHAR_DQUOTE)) begin
            mode_d = MODE_IDLE;
            cnt_d  = cnt_bump;
          end else if (b == CHAR_BSLASH) begin
            mode_d = (mode_q == MODE_SQ) ? MODE_SQ_ESC : MODE_DQ_ESC;
          end
        end
        MODE_SQ_ESC: mode_d = MODE_SQ;
        MODE_DQ_ESC: mode_d = MODE_DQ;
        default: begin
          // idle, and the unused codes behave the same
          if (is_sep) begin
            mode_d = MODE_IDLE;
          end else if (b == CHAR_SQUOTE) begin
            mode_d = MODE_SQ;
          end else if (b == CHAR_DQUOTE) begin
            mode_d = MODE_DQ;
          end else begin
            mode_d = MODE_PLAIN;
          end
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    push_o.count = 2'd0;
    push_o.r0    = '{kind: KIND_BYTE, token_byte: b, token_index: cnt_q, last_of_run: 1'b1};
    push_o.r1    = '{kind: KIND_DONE, token_byte: '0, token_index: cnt_bump,
                     last_of_run: 1'b1};
    if (eol) begin
      push_o.r0.token_byte = '0;
      unique case (mode_q)
        MODE_PLAIN: begin
          push_o.count          = 2'd2;
          push_o.r0.kind        = KIND_END;
          push_o.r0.last_of_run = 1'b0;
        end
        MODE_SQ, MODE_DQ, MODE_SQ_ESC, MODE_DQ_ESC: begin
          push_o.count   = 2'd1;
          push_o.r0.kind = KIND_ERROR;
        end
        default: begin
          push_o.count   = 2'd1;
          push_o.r0.kind = KIND_DONE;
        end
      endcase
    end else begin
      unique case (mode_q)
        MODE_PLAIN: begin
          push_o.count = 2'd1;
          if (is_sep) begin
            push_o.r0.kind       = KIND_END;
            push_o.r0.token_byte = '0;
          end
        end
        MODE_SQ, MODE_DQ: begin
          if ((mode_q == MODE_SQ && b == CHAR_SQUOTE) ||
              (mode_q == MODE_DQ && b == CHAR_DQUOTE)) begin
            push_o.count         = 2'd1;
            push_o.r0.kind       = KIND_END;
            push_o.r0.token_byte = '0;
          end else if (b != CHAR_BSLASH) begin
            push_o.count = 2'd1;
          end
        end
        MODE_SQ_ESC, MODE_DQ_ESC: push_o.count = 2'd1;
        default: begin
          if (!is_sep && b != CHAR_SQUOTE && b != CHAR_DQUOTE) begin
            push_o.count = 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // End of line always starts a fresh line.
  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && eol |=> mode_q == MODE_IDLE && cnt_q == '0)
    else $error("state not cleared after end of line");

  // Two results only when a bare token is closed by end of line.
  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |-> eol && mode_q == MODE_PLAIN)
    else $error("unexpected second result");

endmodule

`default_nettype wire

@@ hw/rtl/qas_result_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per beat.
`timescale 1ns / 1ps
`default_nettype none

module qas_result_fifo #(
  parameter int unsigned Depth = qas_pkg::QAS_RES_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire qas_pkg::push_t push_i,
  output logic                room_o,
  qas_stream_if.source        res_o
);
  import qas_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_nx;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr_nx = ptr_inc(wr_ptr_q);
  assign pop       = res_o.valid && res_o.ready;
  assign room_o    = cnt_q <= CntW'(Depth - 2);

  assign res_o.valid = cnt_q != '0;
  assign res_o.data  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.count == 2'd1) begin
      wr_ptr_d = wr_ptr_nx;
    end else if (push_i.count == 2'd2) begin
      wr_ptr_d = ptr_inc(wr_ptr_nx);
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> (int'(cnt_q) + int'(push_i.count)) <= int'(Depth))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue count out of range");

endmodule

`default_nettype wire
